[rtl/brle_pkg.sv]
// Shared types and constants for the binary run length encoder.
package brle_pkg;

  localparam int CODE_W         = 16;  // run_code field width
  localparam int CFG_W          = 5;   // code_width register width
  localparam int MAX_CODE_WIDTH = 16;  // default limit on the code width
  localparam int DEF_CODE_WIDTH = 4;   // code_width after reset
  localparam int MAX_PUSH       = 3;   // most codes one input word can cause
  localparam int QDEPTH         = 4;   // output queue entries
  localparam int QCNT_W         = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              last;
  } code_word_t;

endpackage

[rtl/brle_if.sv]
// Valid/ready channel interfaces for the encoder's input and result words.
interface brle_in_if;
  logic valid;
  logic ready;
  logic data_bit;
  logic end_of_stream;

  modport source (output valid, output data_bit, output end_of_stream, input ready);
  modport sink (input valid, input data_bit, input end_of_stream, output ready);
endinterface

interface brle_out_if;
  logic                          valid;
  logic                          ready;
  logic [brle_pkg::CODE_W-1:0]   run_code;
  logic                          last_code;

  modport source (output valid, output run_code, output last_code, input ready);
  modport sink (input valid, input run_code, input last_code, output ready);
endinterface

[rtl/binary_run_length_encoder_unit.sv]
// Binary run length encoder: bit stream in, fixed-width run length codes out.
//
// Each input word carries one stream bit and an end-of-stream flag. The block
// emits the lengths of alternating runs, starting with a run of ones (a zero
// code comes first when the stream opens with a zero bit). A run that reaches
// the largest code 2^w-1 and continues emits that code, then a zero code for
// the empty opposite run, and counting restarts. The word with end_of_stream
// set closes the open run; that code has last_code high and the encoder is
// ready for a new stream. w is code_width clamped to 1..min(MAX_CODE_WIDTH,16);
// write code_width only while the block is idle. Rate: the run state updates
// in the same cycle a word is accepted and its codes drop into a four-entry
// output queue, so one input word is taken per cycle while each word yields
// at most one code and out_ch.ready stays high. The output port drains one
// code per cycle while ready, so a word that yields two or three codes
// stalls the input: it is held while the queue holds more than one code.
module binary_run_length_encoder_unit #(
  parameter int MAX_CODE_WIDTH = brle_pkg::MAX_CODE_WIDTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  brle_in_if.sink                     in_ch,
  brle_out_if.source                  out_ch,
  input  logic                        cfg_wr_en,
  input  logic [brle_pkg::CFG_W-1:0]  cfg_wr_data
);

  localparam int WLIM_I = (MAX_CODE_WIDTH > brle_pkg::CODE_W) ? brle_pkg::CODE_W :
                          ((MAX_CODE_WIDTH < 1) ? 1 : MAX_CODE_WIDTH);
  localparam logic [brle_pkg::CFG_W-1:0] WLIM = brle_pkg::CFG_W'(WLIM_I);
  // Width after reset, clamped like a written width
  localparam int DEF_W_I = (brle_pkg::DEF_CODE_WIDTH > WLIM_I) ? WLIM_I :
                           ((brle_pkg::DEF_CODE_WIDTH < 1) ? 1 : brle_pkg::DEF_CODE_WIDTH);
  localparam int CW = brle_pkg::CODE_W;
  localparam int QW = brle_pkg::QCNT_W;

  // Largest run code for the current width, kept precomputed
  logic [CW-1:0]                 maxc_r, maxc_nxt;
  logic [brle_pkg::CFG_W-1:0]    wclamp;

  // Run state
  logic                          sym_r, sym_nxt;
  logic [CW-1:0]                 cnt_r, cnt_nxt;
  logic                          started_r, started_nxt;

  // Output queue: entry 0 is the word on the output port
  brle_pkg::code_word_t          q_r   [brle_pkg::QDEPTH];
  brle_pkg::code_word_t          q_nxt [brle_pkg::QDEPTH];
  logic [QW-1:0]                 qcnt_r, qcnt_nxt;

  // Codes caused by the word being accepted
  brle_pkg::code_word_t          push  [brle_pkg::MAX_PUSH];
  logic [1:0]                    npush;

  logic                          in_fire;
  logic                          pop;
  logic [QW-1:0]                 base;
  logic [QW-1:0]                 k;

  assign in_ch.ready = (qcnt_r <= QW'(brle_pkg::QDEPTH - brle_pkg::MAX_PUSH));
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_ch.valid     = (qcnt_r != '0);
  assign out_ch.run_code  = q_r[0].code;
  assign out_ch.last_code = q_r[0].last;
  assign pop         = out_ch.valid && out_ch.ready;

  // Clamp the written width and turn it into the largest code
  always_comb begin
    wclamp = cfg_wr_data;
    if (wclamp == '0) begin
      wclamp = brle_pkg::CFG_W'(1);
    end else if (wclamp > WLIM) begin
      wclamp = WLIM;
    end
    maxc_nxt = maxc_r;
    if (cfg_wr_en) begin
      maxc_nxt = CW'(((CW+1)'(1) << wclamp) - (CW+1)'(1));
    end
  end

  // Run tracking: update state and collect up to three codes in order
  always_comb begin
    sym_nxt     = sym_r;
    cnt_nxt     = cnt_r;
    started_nxt = started_r;
    npush       = '0;
    for (int i = 0; i < brle_pkg::MAX_PUSH; i++) begin
      push[i] = '{code: '0, last: 1'b0};
    end
    if (in_fire) begin
      if (!started_r) begin
        // Stream opens with zeros: emit the empty ones run first
        started_nxt = 1'b1;
        if (!in_ch.data_bit) begin
          push[npush] = '{code: '0, last: 1'b0};
          npush       = npush + 2'd1;
        end
        sym_nxt = in_ch.data_bit;
        cnt_nxt = CW'(1);
      end else if (in_ch.data_bit == sym_r) begin
        if (cnt_r >= maxc_r) begin
          // Saturated run continues: emit max, then an empty opposite run
          push[npush] = '{code: maxc_r, last: 1'b0};
          npush       = npush + 2'd1;
          push[npush] = '{code: '0, last: 1'b0};
          npush       = npush + 2'd1;
          cnt_nxt     = CW'(1);
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end else begin
        push[npush] = '{code: (cnt_r > maxc_r) ? maxc_r : cnt_r, last: 1'b0};
        npush       = npush + 2'd1;
        sym_nxt     = in_ch.data_bit;
        cnt_nxt     = CW'(1);
      end
      if (in_ch.end_of_stream) begin
        // Flush the open run and return to the idle stream state
        push[npush] = '{code: (cnt_nxt > maxc_r) ? maxc_r : cnt_nxt, last: 1'b1};
        npush       = npush + 2'd1;
        sym_nxt     = 1'b1;
        cnt_nxt     = '0;
        started_nxt = 1'b0;
      end
    end
  end

  // Queue: shift on pop, append new codes behind the survivors
  always_comb begin
    base = qcnt_r - QW'(pop);
    k    = '0;
    for (int i = 0; i < brle_pkg::QDEPTH; i++) begin
      q_nxt[i] = q_r[i];
    end
    if (pop) begin
      for (int i = 0; i < brle_pkg::QDEPTH - 1; i++) begin
        q_nxt[i] = q_r[i+1];
      end
    end
    for (int i = 0; i < brle_pkg::QDEPTH; i++) begin
      k = QW'(i) - base;
      if (in_fire && (QW'(i) >= base) && (k < QW'(npush))) begin
        q_nxt[i] = push[k[1:0]];
      end
    end
    qcnt_nxt = base + (in_fire ? QW'(npush) : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      maxc_r    <= CW'((32'(1) << DEF_W_I) - 32'(1));
      sym_r     <= 1'b1;
      cnt_r     <= '0;
      started_r <= 1'b0;
      qcnt_r    <= '0;
    end else begin
      maxc_r    <= maxc_nxt;
      sym_r     <= sym_nxt;
      cnt_r     <= cnt_nxt;
      started_r <= started_nxt;
      qcnt_r    <= qcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < brle_pkg::QDEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

`ifndef NO_ASSERTIONS
  a_qcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    qcnt_r <= QW'(brle_pkg::QDEPTH))
    else $error("output queue overfilled");

  a_room_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> (qcnt_r <= QW'(brle_pkg::QDEPTH - brle_pkg::MAX_PUSH)))
    else $error("word accepted without room for its codes");

  a_eos_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_ch.end_of_stream) |=> (!started_r && sym_r && cnt_r == '0))
    else $error("stream state not cleared after end of stream");

  a_open_run_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    started_r |-> (cnt_r != '0))
    else $error("open run with zero length");

  a_eos_gives_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_ch.end_of_stream) |=> (qcnt_r != '0))
    else $error("end of stream left no code queued");
`endif

endmodule
